@@ rtl/rpt_pkg.sv @@
package rpt_pkg;

  // Default number of relay channels
  localparam int unsigned RPT_CHANNELS = 8;

  // Relay bits shown on the result item
  localparam int unsigned RPT_SHOWN = 8;

  // Function codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_OPERATE = 2'd1;
  localparam logic [1:0] FUNC_SELECT  = 2'd2;

  // Control codes
  localparam logic [2:0] CODE_LATCH_ON  = 3'd0;
  localparam logic [2:0] CODE_LATCH_OFF = 3'd1;
  localparam logic [2:0] CODE_PULSE_ON  = 3'd2;
  localparam logic [2:0] CODE_PULSE_OFF = 3'd3;

  // Status codes
  localparam logic STATUS_SUCCESS       = 1'b0;
  localparam logic STATUS_NOT_SUPPORTED = 1'b1;

  // Per-channel action for one item
  typedef struct packed {
    logic tick;
    logic bit_set;
    logic bit_clear;
    logic train_start;
    logic train_cancel;
  } chan_ctl_t;

endpackage

@@ rtl/rpt_if.sv @@
interface rpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  control_code;
  logic [15:0] point_index;
  logic [7:0]  pulse_count;
  logic [31:0] on_time_ms;
  logic [31:0] off_time_ms;

  modport source (
    output valid, func, control_code, point_index, pulse_count, on_time_ms, off_time_ms,
    input  ready
  );
  modport sink (
    input  valid, func, control_code, point_index, pulse_count, on_time_ms, off_time_ms,
    output ready
  );
endinterface

interface rpt_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] relay_outputs;

  modport source (
    output valid, status, relay_outputs,
    input  ready
  );
  modport sink (
    input  valid, status, relay_outputs,
    output ready
  );
endinterface

@@ rtl/rpt_channel.sv @@
module rpt_channel
  import rpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  chan_ctl_t   ctl,
  input  logic [63:0] now,
  input  logic [63:0] now_p1,
  input  logic [7:0]  cnt,
  input  logic [31:0] ton,
  input  logic [31:0] toff,
  output logic        bit_nxt
);

  logic [63:0] due_r, due_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  pulses_r, pulses_nxt;
  logic [31:0] ton_r, ton_nxt;
  logic [31:0] toff_r, toff_nxt;
  logic        bit_r;
  logic        due_hit;
  logic [63:0] due_plus_on;
  logic [63:0] due_plus_off;

  // Toggle when a train is running and the advanced clock has reached the due time
  assign due_hit      = (pulses_r != 8'd0) && (now_p1 >= due_r);
  assign due_plus_on  = due_r + {32'd0, ton_r};
  assign due_plus_off = due_r + {32'd0, toff_r};

  // Next channel state for the item in progress
  always_comb begin
    due_nxt    = due_r;
    phase_nxt  = phase_r;
    pulses_nxt = pulses_r;
    ton_nxt    = ton_r;
    toff_nxt   = toff_r;
    bit_nxt    = bit_r;
    if (ctl.tick && due_hit) begin
      if (phase_r) begin
        bit_nxt    = 1'b0;
        phase_nxt  = 1'b0;
        due_nxt    = due_plus_off;
        pulses_nxt = pulses_r - 8'd1;
      end else begin
        bit_nxt   = 1'b1;
        phase_nxt = 1'b1;
        due_nxt   = due_plus_on;
      end
    end
    if (ctl.bit_set) begin
      bit_nxt = 1'b1;
    end
    if (ctl.bit_clear) begin
      bit_nxt = 1'b0;
    end
    // Start a train: due at once, beginning in the off phase
    if (ctl.train_start) begin
      due_nxt    = now;
      phase_nxt  = 1'b0;
      pulses_nxt = cnt;
      ton_nxt    = ton;
      toff_nxt   = toff;
    end
    // Cancel the train and drop the output
    if (ctl.train_cancel) begin
      pulses_nxt = 8'd0;
      bit_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      pulses_r <= 8'd0;
      bit_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pulses_r <= pulses_nxt;
      bit_r    <= bit_nxt;
    end
  end

  // Times are only read while a train runs, which pulse on always writes first
  always_ff @(posedge clk) begin
    due_r  <= due_nxt;
    ton_r  <= ton_nxt;
    toff_r <= toff_nxt;
  end

endmodule

@@ rtl/relay_pulse_train_controller_unit.sv @@
// Channel   Dir  Handshake          Payload
// in_item   in   valid/ready        func, control_code, point_index, pulse_count,
//                                   on_time_ms, off_time_ms
// out_item  out  valid/ready        status, relay_outputs
//
// One item per cycle sustained while out_item is ready; each item gives one result,
// registered first in the input register, then in the result register.
// The channel compare and due-time add stand between the two registers.
// Reset is synchronous, active low; it clears the clock, trains, relay bits and valids.
// A stalled result holds in the result register while the input register keeps the
// next item; the input stalls only when both are full.
module relay_pulse_train_controller_unit
  import rpt_pkg::*;
#(
  parameter int unsigned CHANNELS = RPT_CHANNELS
) (
  input  logic   clk,
  input  logic   rst_n,
  rpt_in_if.sink    in_item,
  rpt_out_if.source out_item
);

  // Input register
  logic        in_valid_r;
  logic [1:0]  func_r;
  logic [2:0]  code_r;
  logic [15:0] idx_r;
  logic [7:0]  cnt_r;
  logic [31:0] ton_r;
  logic [31:0] toff_r;

  // Result register
  logic        out_valid_r;
  logic        status_r;
  logic [RPT_SHOWN-1:0] relay_r;

  // Millisecond clock and its increment
  logic [63:0] now_r, now_p1_r;

  logic        advance;
  logic        in_take;
  logic        is_tick;
  logic        is_operate;
  logic        is_select;
  logic        ok;
  logic        status_nxt;
  logic [CHANNELS-1:0] bits_nxt;
  logic [RPT_SHOWN-1:0] relay_nxt;

  // Move the held item into the result register when that register is free
  assign advance  = in_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !in_valid_r || advance;
  assign in_take  = in_item.valid && in_item.ready;

  assign is_tick    = (func_r == FUNC_TICK);
  assign is_operate = (func_r == FUNC_OPERATE);
  assign is_select  = (func_r == FUNC_SELECT);

  // Validate index and control code
  assign ok = (idx_r < 16'(CHANNELS)) &&
              ((code_r == CODE_LATCH_ON) || (code_r == CODE_LATCH_OFF) ||
               (code_r == CODE_PULSE_ON) || (code_r == CODE_PULSE_OFF));

  always_comb begin
    status_nxt = STATUS_SUCCESS;
    if ((is_operate || is_select) && !ok) begin
      status_nxt = STATUS_NOT_SUPPORTED;
    end
  end

  // Per-channel decode and state
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    chan_ctl_t ctl;
    logic      hit;

    assign hit = advance && is_operate && ok && (idx_r == 16'(c));
    assign ctl.tick         = advance && is_tick;
    assign ctl.bit_set      = hit && (code_r == CODE_LATCH_ON);
    assign ctl.bit_clear    = hit && (code_r == CODE_LATCH_OFF);
    assign ctl.train_start  = hit && (code_r == CODE_PULSE_ON);
    assign ctl.train_cancel = hit && (code_r == CODE_PULSE_OFF);

    rpt_channel u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .now     (now_r),
      .now_p1  (now_p1_r),
      .cnt     (cnt_r),
      .ton     (ton_r),
      .toff    (toff_r),
      .bit_nxt (bits_nxt[c])
    );
  end

  // Show the low channels, zero above the channel count
  for (genvar i = 0; i < RPT_SHOWN; i++) begin : g_show
    if (i < CHANNELS) begin : g_live
      assign relay_nxt[i] = bits_nxt[i];
    end else begin : g_pad
      assign relay_nxt[i] = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      now_r       <= 64'd0;
      now_p1_r    <= 64'd1;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance && is_tick) begin
        now_r    <= now_p1_r;
        now_p1_r <= now_p1_r + 64'd1;
      end
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_item.func;
      code_r <= in_item.control_code;
      idx_r  <= in_item.point_index;
      cnt_r  <= in_item.pulse_count;
      ton_r  <= in_item.on_time_ms;
      toff_r <= in_item.off_time_ms;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= status_nxt;
      relay_r  <= relay_nxt;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.status        = status_r;
  assign out_item.relay_outputs = relay_r;

`ifndef SYNTHESIS
  a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
    now_p1_r == now_r + 64'd1)
    else $error("clock increment register out of step");

  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick |=> now_r == $past(now_r) + 64'd1)
    else $error("tick did not advance the clock");

  a_tick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick |=> status_r == STATUS_SUCCESS)
    else $error("tick reported a failure");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(idx_r) && $stable(func_r))
    else $error("held item lost before it moved on");

  a_no_cmd_clock: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !is_tick |=> $stable(now_r))
    else $error("clock moved on a command");
`endif

endmodule
